[rtl/core/assert_macros.svh]
// Assertion macros shared by the stack RTL.
// Depends on a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that a condition never holds outside reset.
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

[rtl/core/swbi_pkg.sv]
// Package for the bounded stack with bottom insert: sizes, codes and the cell control bundle.
// Depends on nothing; used by swbi_cell and stack_with_bottom_insert_top.
`default_nettype none

package swbi_pkg;

    // Storage depth and derived widths.
    localparam int DEPTH = 16;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CAP_W = 5;
    localparam int OCC_W = 5;
    localparam int LIM_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;
    localparam int WORD_W = 32;

    // Command codes.
    localparam logic [1:0] CMD_PUSH   = 2'd0;
    localparam logic [1:0] CMD_INSERT = 2'd1;
    localparam logic [1:0] CMD_POP    = 2'd2;
    localparam logic [1:0] CMD_MIDDLE = 2'd3;

    // Status codes.
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_OVERFLOW = 2'd1;
    localparam logic [1:0] ST_EMPTY    = 2'd2;

    // Word returned by a pop on an empty stack.
    localparam logic signed [WORD_W-1:0] EMPTY_POP_WORD = 32'sh7FFF_FFFF;

    // Reset value of the capacity register.
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    // Control broadcast from the top level to every cell.
    typedef struct packed {
        logic             shift_en;
        logic             write_en;
        logic [IDX_W-1:0] wr_idx;
        logic [IDX_W-1:0] rd_idx;
    } cell_ctl_t;

endpackage

`default_nettype wire

[rtl/core/swbi_cell.sv]
// One storage cell of the stack chain: holds a word, takes its lower neighbor's word on a shift.
// Depends on swbi_pkg for widths and the cell control struct.
`default_nettype none

module swbi_cell
(
    input  wire                                   clk,
    input  wire         [swbi_pkg::IDX_W-1:0]     cell_idx,
    input  swbi_pkg::cell_ctl_t                   ctl,
    input  wire  signed [swbi_pkg::WORD_W-1:0]    value,
    input  wire  signed [swbi_pkg::WORD_W-1:0]    prev_word,
    output logic signed [swbi_pkg::WORD_W-1:0]    word_out,
    output logic signed [swbi_pkg::WORD_W-1:0]    rd_word
);

    logic signed [swbi_pkg::WORD_W-1:0] word_reg;
    logic signed [swbi_pkg::WORD_W-1:0] word_next;

    // A shift takes the neighbor's word; a push writes the first free cell, just above the top.
    always_comb
    begin
        word_next = word_reg;
        if (ctl.shift_en)
        begin
            word_next = prev_word;
        end
        else if (ctl.write_en && (ctl.wr_idx == cell_idx))
        begin
            word_next = value;
        end
    end

    // Payload storage; no reset since unwritten entries are never read.
    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    // Hand the word up the chain and drive the read bus when selected.
    assign word_out = word_reg;
    assign rd_word  = (ctl.rd_idx == cell_idx) ? word_reg : '0;

endmodule

`default_nettype wire

[rtl/core/stack_with_bottom_insert_top.sv]
// A command accepted at an edge has its result registered and on the outputs the next cycle.
// Throughput: one command per cycle; every cell updates in parallel, bottom insert included.
// busy is always low, and done marks each result beat for exactly one cycle.
// Reset: asynchronous, active low; clears the entry count, the result strobe and sets capacity 16.
// Stored words are not cleared; only entries below the count are ever read.
// Top level of the bounded stack; holds count, capacity and the result register.
// Depends on swbi_pkg, swbi_cell and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module stack_with_bottom_insert_top
(
    input  wire                                   clk,
    input  wire                                   rst_n,
    input  wire                                   start,
    output logic                                  busy,
    input  wire         [1:0]                     cmd,
    input  wire  signed [swbi_pkg::WORD_W-1:0]    value,
    input  wire                                   cfg_we,
    input  wire         [swbi_pkg::CAP_W-1:0]     cfg_data,
    output logic                                  done,
    output logic signed [swbi_pkg::WORD_W-1:0]    data,
    output logic        [1:0]                     status,
    output logic        [swbi_pkg::OCC_W-1:0]     occupancy
);

    logic [swbi_pkg::CNT_W-1:0]          count_reg;
    logic [swbi_pkg::CNT_W-1:0]          count_next;
    logic [swbi_pkg::CAP_W-1:0]          cap_reg;
    logic [swbi_pkg::LIM_W-1:0]          cap_ext;
    logic [swbi_pkg::LIM_W-1:0]          limit;
    logic                                full;
    logic                                empty;
    logic                                accept;
    logic                                done_reg;
    logic signed [swbi_pkg::WORD_W-1:0]  data_reg;
    logic signed [swbi_pkg::WORD_W-1:0]  data_next;
    logic [1:0]                          status_reg;
    logic [1:0]                          status_next;
    logic signed [swbi_pkg::WORD_W-1:0]  rd_bus;
    logic                                overflow_beat;
    swbi_pkg::cell_ctl_t                 ctl;

    logic signed [swbi_pkg::WORD_W-1:0]  chain   [swbi_pkg::DEPTH];
    logic signed [swbi_pkg::WORD_W-1:0]  rd_word [swbi_pkg::DEPTH];

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Effective capacity: zero counts as one, anything above the depth saturates.
    always_comb
    begin
        cap_ext = swbi_pkg::LIM_W'(cap_reg);
        limit   = cap_ext;
        if (cap_ext == '0)
        begin
            limit = swbi_pkg::LIM_W'(1);
        end
        else if (cap_ext > swbi_pkg::LIM_W'(swbi_pkg::DEPTH))
        begin
            limit = swbi_pkg::LIM_W'(swbi_pkg::DEPTH);
        end
    end

    assign full  = swbi_pkg::LIM_W'(count_reg) >= limit;
    assign empty = (count_reg == '0);

    // Command decode: cell controls, next count and the result beat.
    always_comb
    begin
        ctl.shift_en = 1'b0;
        ctl.write_en = 1'b0;
        ctl.wr_idx   = count_reg[swbi_pkg::IDX_W-1:0];
        ctl.rd_idx   = swbi_pkg::IDX_W'(count_reg >> 1);
        count_next   = count_reg;
        status_next  = swbi_pkg::ST_OK;
        data_next    = '0;
        unique case (cmd)
            swbi_pkg::CMD_PUSH:
            begin
                if (full)
                begin
                    status_next = swbi_pkg::ST_OVERFLOW;
                end
                else
                begin
                    ctl.write_en = accept;
                    count_next   = count_reg + swbi_pkg::CNT_W'(1);
                end
            end
            swbi_pkg::CMD_INSERT:
            begin
                if (full)
                begin
                    status_next = swbi_pkg::ST_OVERFLOW;
                end
                else
                begin
                    ctl.shift_en = accept;
                    count_next   = count_reg + swbi_pkg::CNT_W'(1);
                end
            end
            swbi_pkg::CMD_POP:
            begin
                ctl.rd_idx = swbi_pkg::IDX_W'(count_reg - swbi_pkg::CNT_W'(1));
                if (empty)
                begin
                    status_next = swbi_pkg::ST_EMPTY;
                    data_next   = swbi_pkg::EMPTY_POP_WORD;
                end
                else
                begin
                    count_next = count_reg - swbi_pkg::CNT_W'(1);
                    data_next  = rd_bus;
                end
            end
            default:
            begin
                if (empty)
                begin
                    status_next = swbi_pkg::ST_EMPTY;
                end
                else
                begin
                    data_next = rd_bus;
                end
            end
        endcase
    end

    // The cell chain; the bottom cell takes the inserted word as its neighbor.
    for (genvar i = 0; i < swbi_pkg::DEPTH; i++)
    begin : g_cell
        logic signed [swbi_pkg::WORD_W-1:0] prev_word;

        if (i == 0)
        begin : g_bottom
            assign prev_word = value;
        end
        else
        begin : g_upper
            assign prev_word = chain[i-1];
        end

        swbi_cell u_cell
        (
            .clk       (clk),
            .cell_idx  (swbi_pkg::IDX_W'(i)),
            .ctl       (ctl),
            .value     (value),
            .prev_word (prev_word),
            .word_out  (chain[i]),
            .rd_word   (rd_word[i])
        );
    end

    // Only the selected cell drives a nonzero word, so an OR collects the read.
    always_comb
    begin
        rd_bus = '0;
        for (int i = 0; i < swbi_pkg::DEPTH; i++)
        begin
            rd_bus = rd_bus | rd_word[i];
        end
    end

    // Control state: count, capacity and the result strobe.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            cap_reg   <= swbi_pkg::CAP_RESET;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= accept;
            if (accept)
            begin
                count_reg <= count_next;
            end
            if (cfg_we)
            begin
                cap_reg <= cfg_data;
            end
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            data_reg   <= data_next;
            status_reg <= status_next;
        end
    end

    assign done      = done_reg;
    assign data      = data_reg;
    assign status    = status_reg;
    assign occupancy = swbi_pkg::OCC_W'(count_reg);

    // A result beat that reports overflow.
    assign overflow_beat = done_reg && (status_reg == swbi_pkg::ST_OVERFLOW);

    // Checks on the control state.
    `ASSERT_NEVER(a_count_range, count_reg > swbi_pkg::CNT_W'(swbi_pkg::DEPTH), "count above depth")
    `ASSERT_CLK(a_accept_done, accept |=> done_reg, "accepted command gave no result beat")
    `ASSERT_CLK(a_idle_no_done, !start |=> !done_reg, "result beat without a command")
    `ASSERT_CLK(a_overflow_hold, overflow_beat |-> $stable(count_reg), "overflow changed the count")

endmodule

`default_nettype wire
